/* design/srdo_pkg.sv */
package srdo_pkg;

  // field widths
  localparam int unsigned ID_W    = 11;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned BYTES   = DATA_W / 8;

  // queue depths
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned OUT_DEPTH_DEF   = 2;

  // register indexes
  localparam logic [CIDX_W-1:0] CFG_NORMAL_ID  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_INVERSE_ID = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_VAL_LIMIT  = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_CYC_LIMIT  = 2'd3;

  // register reset values
  localparam logic [ID_W-1:0]   NORMAL_ID_RST  = 11'h101;
  localparam logic [ID_W-1:0]   INVERSE_ID_RST = 11'h102;
  localparam logic [TIME_W-1:0] VAL_LIMIT_RST  = 16'd100;
  localparam logic [TIME_W-1:0] CYC_LIMIT_RST  = 16'd1100;

  // command codes
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_ACCEPTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_OK       = 3'd1;
  localparam logic [STAT_W-1:0] ST_TIMEOUT  = 3'd2;
  localparam logic [STAT_W-1:0] ST_MISSING  = 3'd3;
  localparam logic [STAT_W-1:0] ST_MISMATCH = 3'd4;
  localparam logic [STAT_W-1:0] ST_CYCLE    = 3'd5;

  localparam logic [LEN_W-1:0]  MAX_LEN = LEN_W'(BYTES);
  localparam logic [TIME_W-1:0] SAT_MAX = '1;

  typedef struct packed {
    logic [ID_W-1:0]   normal_id;
    logic [ID_W-1:0]   inverse_id;
    logic [TIME_W-1:0] val_limit;
    logic [TIME_W-1:0] cyc_limit;
  } cfg_t;

  // classified item between front and back
  typedef struct packed {
    logic              is_tick;
    logic              is_normal;
    logic              is_inverse;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [TIME_W-1:0] elapsed;
  } result_t;

  function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
    sat_inc = (v == SAT_MAX) ? v : v + TIME_W'(1);
  endfunction

endpackage

/* design/srdo_fifo.sv */
module srdo_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr_r];

  // pointer and fill count update
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= wdata;
    end
  end

endmodule

/* design/srdo_front.sv */
module srdo_front #(
  parameter int unsigned QUEUE_DEPTH = srdo_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  srdo_pkg::cfg_t                cfg,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_command,
  input  logic [srdo_pkg::ID_W-1:0]     in_frame_id,
  input  logic [srdo_pkg::DATA_W-1:0]   in_frame_data,
  input  logic [srdo_pkg::LEN_W-1:0]    in_frame_length,
  input  logic                          q_pop,
  output srdo_pkg::item_t               q_item,
  output logic                          q_empty
);
  import srdo_pkg::*;

  item_t            item;
  logic [$bits(item_t)-1:0] q_raw;

  // classify the incoming item against the configured identifiers
  always_comb begin
    item.is_tick    = (in_command == CMD_TICK);
    item.is_normal  = (in_frame_id == cfg.normal_id);
    item.is_inverse = (in_frame_id == cfg.inverse_id);
    item.len        = (in_frame_length > MAX_LEN) ? MAX_LEN : in_frame_length;
    item.data       = in_frame_data;
  end

  // decoupling queue toward the back end
  srdo_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (item),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (q_raw),
    .empty (q_empty)
  );

  assign q_item = item_t'(q_raw);

endmodule

/* design/srdo_back.sv */
module srdo_back (
  input  logic              clk,
  input  logic              rst_n,
  input  srdo_pkg::cfg_t    cfg,
  input  srdo_pkg::item_t   q_item,
  input  logic              q_empty,
  output logic              q_pop,
  input  logic              res_full,
  output logic              res_push,
  output srdo_pkg::result_t res
);
  import srdo_pkg::*;

  logic              waiting_r, waiting_nxt;
  logic              have_prev_r, have_prev_nxt;
  logic [TIME_W-1:0] val_cnt_r, val_cnt_nxt;
  logic [TIME_W-1:0] cyc_cnt_r, cyc_cnt_nxt;
  logic [DATA_W-1:0] held_data_r;
  logic [LEN_W-1:0]  held_len_r;
  logic              store;
  logic              take;
  logic [TIME_W-1:0] val_inc;
  logic [BYTES-1:0]  byte_ok;
  logic              match;

  // one item per cycle whenever the result queue has room
  assign take  = !q_empty && !res_full;
  assign q_pop = take;
  assign val_inc = sat_inc(val_cnt_r);

  // bytewise complement check over the held length
  always_comb begin
    for (int i = 0; i < BYTES; i++) begin
      byte_ok[i] = (held_data_r[8*i +: 8] == ~q_item.data[8*i +: 8]) ||
                   (LEN_W'(i) >= held_len_r);
    end
    match = &byte_ok;
  end

  // pair validation step
  always_comb begin
    waiting_nxt   = waiting_r;
    have_prev_nxt = have_prev_r;
    val_cnt_nxt   = val_cnt_r;
    cyc_cnt_nxt   = cyc_cnt_r;
    store         = 1'b0;
    res_push      = 1'b0;
    res.status    = ST_ACCEPTED;
    res.elapsed   = '0;
    if (take) begin
      if (q_item.is_tick) begin
        cyc_cnt_nxt = sat_inc(cyc_cnt_r);
        if (waiting_r) begin
          val_cnt_nxt = val_inc;
          if (val_inc >= cfg.val_limit) begin
            waiting_nxt = 1'b0;
            res_push    = 1'b1;
            res.status  = ST_TIMEOUT;
          end
        end
      end else if (!waiting_r) begin
        if (!q_item.is_inverse) begin
          store       = 1'b1;
          val_cnt_nxt = '0;
          waiting_nxt = 1'b1;
          res_push    = 1'b1;
          res.status  = ST_ACCEPTED;
        end
      end else if (q_item.is_normal) begin
        waiting_nxt = 1'b0;
        res_push    = 1'b1;
        res.status  = ST_MISSING;
      end else if (q_item.is_inverse) begin
        waiting_nxt = 1'b0;
        res_push    = 1'b1;
        if (!match) begin
          res.status = ST_MISMATCH;
        end else begin
          res.status    = (have_prev_r && (cyc_cnt_r > cfg.cyc_limit)) ? ST_CYCLE : ST_OK;
          res.elapsed   = have_prev_r ? cyc_cnt_r : '0;
          have_prev_nxt = 1'b1;
          cyc_cnt_nxt   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r   <= 1'b0;
      have_prev_r <= 1'b0;
      val_cnt_r   <= '0;
      cyc_cnt_r   <= '0;
    end else begin
      waiting_r   <= waiting_nxt;
      have_prev_r <= have_prev_nxt;
      val_cnt_r   <= val_cnt_nxt;
      cyc_cnt_r   <= cyc_cnt_nxt;
    end
  end

  // held normal frame
  always_ff @(posedge clk) begin
    if (store) begin
      held_data_r <= q_item.data;
      held_len_r  <= q_item.len;
    end
  end

`ifndef SYNTH
  // entering the wait always reports the accepted normal frame
  a_wait_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(waiting_r) |-> $past(res_push && res.status == ST_ACCEPTED))
    else $error("wait entered without accepted report");

  // a good pair restarts the cycle counter
  a_cycle_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && (res.status == ST_OK || res.status == ST_CYCLE)) |=> cyc_cnt_r == '0)
    else $error("cycle counter not restarted after good pair");

  // elapsed time only accompanies a good pair
  a_elapsed_good: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.elapsed != '0) |-> (res.status == ST_OK || res.status == ST_CYCLE))
    else $error("elapsed time on non pair result");

  // results are produced only while an item is taken
  a_push_take: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (take && !res_full))
    else $error("result produced without an item");
`endif

endmodule

/* design/srdo_pair_validator_unit.sv */
// srdo pair validator
// checks pairs of safety data frames: a normal frame followed by its bitwise
// inverted companion. input items are received frames or timer ticks.
// input channel: present an item with in_push; it transfers at a clock edge
// where in_push is high and in_full is low. one item per cycle is taken while in_full is low.
// result channel: the oldest result sits on out_status / out_cycle_elapsed
// while out_empty is low; it transfers when out_pop is high. an item gives
// zero or one result.
// throughput: one item per cycle while the result queue has room, set by the
// combinational evaluation step in the back end reading the held frame registers.
// stalls: when out_pop stays low the result queue fills, the back end stops
// draining the item queue, and in_full rises once that queue is full too.
// configuration: write cfg_index / cfg_data with cfg_we, only while idle.
// reset (rst_n low, synchronous) empties both queues, restores the default
// identifiers and limits, and returns the checker to idle with no prior pair.
module srdo_pair_validator_unit #(
  parameter int unsigned QUEUE_DEPTH = srdo_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH   = srdo_pkg::OUT_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [srdo_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [srdo_pkg::TIME_W-1:0]   cfg_data,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_command,
  input  logic [srdo_pkg::ID_W-1:0]     in_frame_id,
  input  logic [srdo_pkg::DATA_W-1:0]   in_frame_data,
  input  logic [srdo_pkg::LEN_W-1:0]    in_frame_length,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [srdo_pkg::STAT_W-1:0]   out_status,
  output logic [srdo_pkg::TIME_W-1:0]   out_cycle_elapsed
);
  import srdo_pkg::*;

  cfg_t    cfg_r;
  item_t   q_item;
  logic    q_empty;
  logic    q_pop;
  logic    res_full;
  logic    res_push;
  result_t res;
  logic [$bits(result_t)-1:0] out_raw;
  result_t out_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.normal_id  <= NORMAL_ID_RST;
      cfg_r.inverse_id <= INVERSE_ID_RST;
      cfg_r.val_limit  <= VAL_LIMIT_RST;
      cfg_r.cyc_limit  <= CYC_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NORMAL_ID:  cfg_r.normal_id  <= cfg_data[ID_W-1:0];
        CFG_INVERSE_ID: cfg_r.inverse_id <= cfg_data[ID_W-1:0];
        CFG_VAL_LIMIT:  cfg_r.val_limit  <= cfg_data;
        CFG_CYC_LIMIT:  cfg_r.cyc_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  // classify and queue
  srdo_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_command      (in_command),
    .in_frame_id     (in_frame_id),
    .in_frame_data   (in_frame_data),
    .in_frame_length (in_frame_length),
    .q_pop           (q_pop),
    .q_item          (q_item),
    .q_empty         (q_empty)
  );

  // pair validation
  srdo_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_item   (q_item),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  // result queue
  srdo_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_raw),
    .empty (out_empty)
  );

  assign out_res           = result_t'(out_raw);
  assign out_status        = out_res.status;
  assign out_cycle_elapsed = out_res.elapsed;

endmodule

/* test/tb_srdo_pair_validator_unit.sv */
module tb_srdo_pair_validator_unit;
  import srdo_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned SETTLE_CYC  = 12;
  localparam int unsigned PHASE_ITEMS = 225;
  localparam int unsigned NUM_PHASES  = 6;
  localparam logic [DATA_W-1:0] PAT_A = 64'h0123_4567_89AB_CDEF;

  // how a stimulus row is checked
  typedef enum logic [1:0] {CHK_MODEL, CHK_QUIET, CHK_FIXED} check_t;

  typedef struct {
    logic              is_cfg;
    logic [CIDX_W-1:0] reg_idx;
    logic [TIME_W-1:0] reg_val;
    logic              cmd;
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  len;
    check_t            chk;
    result_t           want;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CIDX_W-1:0]   cfg_index;
  logic [TIME_W-1:0]   cfg_data;
  logic                in_push;
  logic                in_full;
  logic                in_command;
  logic [ID_W-1:0]     in_frame_id;
  logic [DATA_W-1:0]   in_frame_data;
  logic [LEN_W-1:0]    in_frame_length;
  logic                out_empty;
  logic                out_pop;
  logic [STAT_W-1:0]   out_status;
  logic [TIME_W-1:0]   out_cycle_elapsed;

  // check mode travelling with the offered item
  check_t              row_chk;
  result_t             row_want;

  // predicted pair checker state and its copy of the registers
  logic [ID_W-1:0]     m_nid  = NORMAL_ID_RST;
  logic [ID_W-1:0]     m_iid  = INVERSE_ID_RST;
  logic [TIME_W-1:0]   m_vlim = VAL_LIMIT_RST;
  logic [TIME_W-1:0]   m_clim = CYC_LIMIT_RST;
  logic                m_waiting = 1'b0;
  logic [DATA_W-1:0]   m_data = '0;
  logic [LEN_W-1:0]    m_len = '0;
  logic [TIME_W-1:0]   m_val = '0;
  logic [TIME_W-1:0]   m_cyc = '0;
  logic                m_prev = 1'b0;

  result_t             verdict_q[$];
  dir_row_t            script[$];
  int unsigned         fail_cnt = 0;
  int unsigned         cycle_cnt = 0;
  int unsigned         live_items = 0;
  int unsigned         pop_hold = 0;
  logic                steady = 1'b0;

  // register values the stimulus is built around
  logic [ID_W-1:0]     cur_nid;
  logic [ID_W-1:0]     cur_iid;
  logic [TIME_W-1:0]   cur_vlim;
  logic [TIME_W-1:0]   cur_clim;

  srdo_pair_validator_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_command        (in_command),
    .in_frame_id       (in_frame_id),
    .in_frame_data     (in_frame_data),
    .in_frame_length   (in_frame_length),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_status        (out_status),
    .out_cycle_elapsed (out_cycle_elapsed)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // saturating tick counter
  function automatic logic [TIME_W-1:0] tick_up(input logic [TIME_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // advance the predicted checker by one item
  function automatic void judge_item(input logic cmd, input logic [ID_W-1:0] id,
                                     input logic [DATA_W-1:0] data,
                                     input logic [LEN_W-1:0] len_in,
                                     output logic has, output result_t res);
    logic [LEN_W-1:0] len;
    logic             same;
    int               b;
    has = 1'b0;
    res = '0;
    len = (len_in > MAX_LEN) ? MAX_LEN : len_in;
    if (cmd == CMD_TICK) begin
      m_cyc = tick_up(m_cyc);
      if (m_waiting) begin
        m_val = tick_up(m_val);
        if (m_val >= m_vlim) begin
          m_waiting = 1'b0;
          has = 1'b1;
          res.status = ST_TIMEOUT;
        end
      end
    end else if (!m_waiting) begin
      if (id != m_iid) begin
        m_data = data;
        m_len = len;
        m_val = '0;
        m_waiting = 1'b1;
        has = 1'b1;
        res.status = ST_ACCEPTED;
      end
    end else if (id == m_nid) begin
      m_waiting = 1'b0;
      has = 1'b1;
      res.status = ST_MISSING;
    end else if (id == m_iid) begin
      m_waiting = 1'b0;
      has = 1'b1;
      same = 1'b1;
      for (b = 0; b < BYTES; b++) begin
        if (b < m_len && m_data[8*b +: 8] != ~data[8*b +: 8]) same = 1'b0;
      end
      if (!same) begin
        res.status = ST_MISMATCH;
      end else begin
        res.elapsed = m_prev ? m_cyc : '0;
        res.status = (m_prev && m_cyc > m_clim) ? ST_CYCLE : ST_OK;
        m_prev = 1'b1;
        m_cyc = '0;
      end
    end
  endfunction

  // observe config writes, input transfers and result transfers
  always @(posedge clk) begin
    logic    has;
    result_t got;
    result_t want;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (verdict_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result status %0d elapsed %0d", $time,
                   out_status, out_cycle_elapsed);
        end else begin
          want = verdict_q.pop_front();
          if (out_status !== want.status) begin
            fail_cnt++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          end
          if (out_cycle_elapsed !== want.elapsed) begin
            fail_cnt++;
            $display("%0t: cycle_elapsed expected %0d actual %0d", $time, want.elapsed,
                     out_cycle_elapsed);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_NORMAL_ID:  m_nid = cfg_data[ID_W-1:0];
          CFG_INVERSE_ID: m_iid = cfg_data[ID_W-1:0];
          CFG_VAL_LIMIT:  m_vlim = cfg_data;
          CFG_CYC_LIMIT:  m_clim = cfg_data;
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        judge_item(in_command, in_frame_id, in_frame_data, in_frame_length, has, got);
        case (row_chk)
          CHK_MODEL: if (has) verdict_q.push_back(got);
          CHK_FIXED: verdict_q.push_back(row_want);
          default: ;
        endcase
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("srdo_pair_validator_unit: mismatch");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result side: random pops, long hold-offs on request
  initial begin
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (pop_hold != 0) begin
        out_pop <= 1'b0;
        repeat (pop_hold) @(posedge clk);
        pop_hold = 0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        out_pop <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // offer one item and wait for its transfer
  task automatic send_item(input logic cmd, input logic [ID_W-1:0] id,
                           input logic [DATA_W-1:0] data, input logic [LEN_W-1:0] len,
                           input check_t chk, input result_t want);
    int unsigned gap;
    if (!steady && $urandom_range(0, 3) == 0) begin
      gap = idle_len();
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push         <= 1'b1;
    in_command      <= cmd;
    in_frame_id     <= id;
    in_frame_data   <= data;
    in_frame_length <= len;
    row_chk         <= chk;
    row_want        <= want;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic send_frame(input logic [ID_W-1:0] id, input logic [DATA_W-1:0] data,
                            input logic [LEN_W-1:0] len);
    send_item(CMD_FRAME, id, data, len, CHK_MODEL, '0);
    live_items++;
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) begin
      send_item(CMD_TICK, ID_W'($urandom_range(0, 2047)), {$urandom, $urandom},
                LEN_W'($urandom_range(0, 15)), CHK_MODEL, '0);
      live_items++;
    end
  endtask

  // stop offering and let the block run dry
  task automatic settle_block();
    in_push <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [TIME_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [ID_W-1:0] nid, input logic [ID_W-1:0] iid,
                          input logic [TIME_W-1:0] vlim, input logic [TIME_W-1:0] clim);
    settle_block();
    cur_nid = nid;
    cur_iid = iid;
    cur_vlim = vlim;
    cur_clim = clim;
    write_reg(CFG_NORMAL_ID, TIME_W'(nid));
    write_reg(CFG_INVERSE_ID, TIME_W'(iid));
    write_reg(CFG_VAL_LIMIT, vlim);
    write_reg(CFG_CYC_LIMIT, clim);
  endtask

  function automatic dir_row_t item_row(input logic cmd, input logic [ID_W-1:0] id,
                                        input logic [DATA_W-1:0] data,
                                        input logic [LEN_W-1:0] len, input check_t chk,
                                        input logic [STAT_W-1:0] status);
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.cmd = cmd;
    r.id = id;
    r.data = data;
    r.len = len;
    r.chk = chk;
    r.want.status = status;
    r.want.elapsed = '0;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CIDX_W-1:0] idx,
                                       input logic [TIME_W-1:0] val);
    dir_row_t r;
    r = item_row(CMD_FRAME, '0, '0, '0, CHK_QUIET, ST_ACCEPTED);
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // frame id that is neither the normal nor the inverse one
  function automatic logic [ID_W-1:0] stray_id();
    logic [ID_W-1:0] id;
    do id = ID_W'($urandom_range(0, 2047)); while (id == cur_nid || id == cur_iid);
    return id;
  endfunction

  // one short sequence: a pair, a timeout, a lost inverse, or noise
  task automatic run_episode();
    int unsigned     pick;
    int unsigned     lim;
    int unsigned     nb;
    int unsigned     k;
    logic [ID_W-1:0] id;
    logic [DATA_W-1:0] data;
    logic [DATA_W-1:0] mate;
    logic [LEN_W-1:0]  len;
    if ($urandom_range(0, 7) == 0) steady = !steady;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 2) == 0) begin
      id = cur_nid;
    end else begin
      do id = ID_W'($urandom_range(0, 2047)); while (id == cur_iid);
    end
    data = {$urandom, $urandom};
    len = LEN_W'($urandom_range(0, 15));
    lim = (cur_vlim > 6) ? 5 : cur_vlim - 1;
    if (pick < 55) begin
      send_ticks($urandom_range(0, 3));
      send_frame(id, data, len);
      send_ticks($urandom_range(0, lim));
      if ($urandom_range(0, 3) == 0)
        send_item(CMD_FRAME, stray_id(), {$urandom, $urandom},
                  LEN_W'($urandom_range(0, 15)), CHK_MODEL, '0);
      // complement over the stored bytes, anything above them
      nb = (len > MAX_LEN) ? BYTES : len;
      mate = {$urandom, $urandom};
      for (k = 0; k < nb; k++) mate[8*k +: 8] = ~data[8*k +: 8];
      if (nb != 0 && $urandom_range(0, 4) == 0)
        mate[$urandom_range(0, 8*nb-1)] = ~mate[$urandom_range(0, 8*nb-1)];
      send_frame(cur_iid, mate, LEN_W'($urandom_range(0, 15)));
    end else if (pick < 70) begin
      send_frame(id, data, len);
      if (cur_vlim <= 12) begin
        send_ticks(cur_vlim);
      end else begin
        send_ticks($urandom_range(1, 4));
        send_frame(cur_nid, {$urandom, $urandom}, len);
      end
    end else if (pick < 85) begin
      send_frame(id, data, len);
      send_ticks($urandom_range(0, lim));
      send_frame(cur_nid, {$urandom, $urandom}, LEN_W'($urandom_range(0, 15)));
    end else begin
      repeat ($urandom_range(1, 3)) begin
        k = $urandom_range(0, 2);
        send_item(logic'($urandom_range(0, 1)),
                  (k == 0) ? cur_nid : (k == 1) ? cur_iid : ID_W'($urandom_range(0, 2047)),
                  {$urandom, $urandom}, LEN_W'($urandom_range(0, 15)), CHK_MODEL, '0);
      end
    end
  endtask

  initial begin
    int unsigned     phase;
    int unsigned     goal;
    logic [ID_W-1:0] eq_id;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_push = 1'b0;
    in_command = CMD_FRAME;
    in_frame_id = '0;
    in_frame_data = '0;
    in_frame_length = '0;
    row_chk = CHK_MODEL;
    row_want = '0;

    // directed rows, starting from the reset registers
    script.push_back(item_row(CMD_TICK, 11'h000, '0, 4'd0, CHK_QUIET, ST_ACCEPTED));
    script.push_back(item_row(CMD_FRAME, 11'h102, '1, 4'd8, CHK_QUIET, ST_ACCEPTED));
    script.push_back(item_row(CMD_FRAME, 11'h101, PAT_A, 4'd8, CHK_FIXED, ST_ACCEPTED));
    script.push_back(item_row(CMD_FRAME, 11'h102, ~PAT_A, 4'd8, CHK_FIXED, ST_OK));
    script.push_back(item_row(CMD_TICK, 11'h7FF, '1, 4'd15, CHK_QUIET, ST_ACCEPTED));
    script.push_back(item_row(CMD_FRAME, 11'h7FF, '1, 4'd15, CHK_FIXED, ST_ACCEPTED));
    script.push_back(item_row(CMD_FRAME, 11'h000, PAT_A, 4'd8, CHK_QUIET, ST_ACCEPTED));
    script.push_back(item_row(CMD_TICK, 11'h000, '0, 4'd0, CHK_QUIET, ST_ACCEPTED));
    script.push_back(item_row(CMD_FRAME, 11'h102, '0, 4'd4, CHK_MODEL, ST_OK));
    // zero stored length always matches
    script.push_back(item_row(CMD_FRAME, 11'h101, PAT_A, 4'd0, CHK_FIXED, ST_ACCEPTED));
    script.push_back(item_row(CMD_FRAME, 11'h102, 64'h5A5A_5A5A_5A5A_5A5A, 4'd3,
                              CHK_MODEL, ST_OK));
    script.push_back(item_row(CMD_FRAME, 11'h101, 64'hFF, 4'd1, CHK_FIXED, ST_ACCEPTED));
    script.push_back(item_row(CMD_FRAME, 11'h102, 64'h01, 4'd1, CHK_FIXED, ST_MISMATCH));
    // second normal frame while waiting
    script.push_back(item_row(CMD_FRAME, 11'h101, PAT_A, 4'd8, CHK_FIXED, ST_ACCEPTED));
    script.push_back(item_row(CMD_FRAME, 11'h101, PAT_A, 4'd8, CHK_FIXED, ST_MISSING));
    // zero validation limit times out on the first tick
    script.push_back(cfg_row(CFG_VAL_LIMIT, 16'd0));
    script.push_back(item_row(CMD_FRAME, 11'h101, PAT_A, 4'd3, CHK_FIXED, ST_ACCEPTED));
    script.push_back(item_row(CMD_TICK, 11'h000, '0, 4'd0, CHK_FIXED, ST_TIMEOUT));
    script.push_back(cfg_row(CFG_VAL_LIMIT, 16'd1));
    script.push_back(cfg_row(CFG_CYC_LIMIT, 16'd1));
    script.push_back(item_row(CMD_FRAME, 11'h123, PAT_A, 4'd2, CHK_FIXED, ST_ACCEPTED));
    script.push_back(item_row(CMD_TICK, 11'h000, '0, 4'd0, CHK_FIXED, ST_TIMEOUT));
    // pair after too many ticks: cycle exceeded
    script.push_back(item_row(CMD_FRAME, 11'h101, PAT_A, 4'd8, CHK_FIXED, ST_ACCEPTED));
    script.push_back(item_row(CMD_FRAME, 11'h102, ~PAT_A, 4'd8, CHK_MODEL, ST_CYCLE));
    // equal identifiers
    script.push_back(cfg_row(CFG_NORMAL_ID, 16'h555));
    script.push_back(cfg_row(CFG_INVERSE_ID, 16'h555));
    script.push_back(item_row(CMD_FRAME, 11'h555, PAT_A, 4'd8, CHK_QUIET, ST_ACCEPTED));
    script.push_back(item_row(CMD_FRAME, 11'h2AA, PAT_A, 4'd8, CHK_FIXED, ST_ACCEPTED));
    script.push_back(item_row(CMD_FRAME, 11'h555, ~PAT_A, 4'd8, CHK_FIXED, ST_MISSING));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[r]) begin
      if (script[r].is_cfg) begin
        settle_block();
        write_reg(script[r].reg_idx, script[r].reg_val);
      end else begin
        send_item(script[r].cmd, script[r].id, script[r].data, script[r].len,
                  script[r].chk, script[r].want);
      end
    end

    // random phases over several register settings
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      steady = 1'b0;
      case (phase)
        0: set_regs(NORMAL_ID_RST, INVERSE_ID_RST, VAL_LIMIT_RST, CYC_LIMIT_RST);
        1: set_regs(11'h000, 11'h7FF, 16'd1, 16'd1);
        2: set_regs(11'h7FF, 11'h000, 16'hFFFF, 16'hFFFF);
        3: set_regs(ID_W'($urandom_range(0, 2047)), ID_W'($urandom_range(0, 2047)),
                    TIME_W'($urandom_range(2, 8)), TIME_W'($urandom_range(5, 40)));
        4: begin
          eq_id = ID_W'($urandom_range(0, 2047));
          set_regs(eq_id, eq_id, 16'd3, 16'd20);
        end
        default: set_regs(ID_W'($urandom_range(0, 2047)), ID_W'($urandom_range(0, 2047)),
                          TIME_W'($urandom_range(1, 65535)),
                          TIME_W'($urandom_range(1, 65535)));
      endcase
      // receiver holds off while the sender keeps offering
      if (phase == 1 || phase == 3) pop_hold = 80;
      goal = live_items + PHASE_ITEMS;
      while (live_items < goal) run_episode();
    end

    settle_block();
    if (fail_cnt == 0) begin
      $display("srdo_pair_validator_unit: match");
    end else begin
      $display("srdo_pair_validator_unit: mismatch");
    end
    $finish;
  end

endmodule
